// ----- src/csl_pkg.sv -----
// Shared types, codes and keyword matcher functions for the C subset lexer.
package csl_pkg;

  // Result queue depth; the input is taken while two slots are free.
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrBits = $clog2(ResDepth);
  localparam int unsigned ResCntBits = $clog2(ResDepth + 1);

  typedef enum logic [4:0] {
    TK_INT     = 5'd0,
    TK_FLOAT   = 5'd1,
    TK_PRINT   = 5'd2,
    TK_RETURN  = 5'd3,
    TK_IDENT   = 5'd4,
    TK_NUM     = 5'd5,
    TK_ASSIGN  = 5'd6,
    TK_PLUS    = 5'd7,
    TK_MINUS   = 5'd8,
    TK_MUL     = 5'd9,
    TK_DIV     = 5'd10,
    TK_SEMI    = 5'd11,
    TK_LPAREN  = 5'd12,
    TK_RPAREN  = 5'd13,
    TK_LBRACE  = 5'd14,
    TK_RBRACE  = 5'd15,
    TK_EOF     = 5'd16,
    TK_UNKNOWN = 5'd17
  } token_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_NUM     = 2'd2,
    MODE_COMMENT = 2'd3
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
  } csl_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        lexical_error;
    logic        last_of_run;
  } csl_out_t;

  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChHash    = "#";
  localparam logic [7:0] ChUscore  = "_";
  localparam logic [7:0] ChDot     = ".";

  // Keyword matcher states: each one but KwDead is a prefix of a keyword.
  localparam logic [4:0] KwStart  = 5'd0;
  localparam logic [4:0] KwDead   = 5'd1;
  localparam logic [4:0] KwI      = 5'd2;
  localparam logic [4:0] KwIn     = 5'd3;
  localparam logic [4:0] KwInt    = 5'd4;
  localparam logic [4:0] KwF      = 5'd5;
  localparam logic [4:0] KwFl     = 5'd6;
  localparam logic [4:0] KwFlo    = 5'd7;
  localparam logic [4:0] KwFloa   = 5'd8;
  localparam logic [4:0] KwFloat  = 5'd9;
  localparam logic [4:0] KwP      = 5'd10;
  localparam logic [4:0] KwPr     = 5'd11;
  localparam logic [4:0] KwPri    = 5'd12;
  localparam logic [4:0] KwPrin   = 5'd13;
  localparam logic [4:0] KwPrint  = 5'd14;
  localparam logic [4:0] KwPrintf = 5'd15;
  localparam logic [4:0] KwR      = 5'd16;
  localparam logic [4:0] KwRe     = 5'd17;
  localparam logic [4:0] KwRet    = 5'd18;
  localparam logic [4:0] KwRetu   = 5'd19;
  localparam logic [4:0] KwRetur  = 5'd20;
  localparam logic [4:0] KwReturn = 5'd21;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic [4:0] kw_next(input logic [4:0] s, input logic [7:0] c);
    logic [4:0] t;
    t = KwDead;
    case (s)
      KwStart: begin
        if (c == "i") t = KwI;
        else if (c == "f") t = KwF;
        else if (c == "p") t = KwP;
        else if (c == "r") t = KwR;
      end
      KwI:     if (c == "n") t = KwIn;
      KwIn:    if (c == "t") t = KwInt;
      KwF:     if (c == "l") t = KwFl;
      KwFl:    if (c == "o") t = KwFlo;
      KwFlo:   if (c == "a") t = KwFloa;
      KwFloa:  if (c == "t") t = KwFloat;
      KwP:     if (c == "r") t = KwPr;
      KwPr:    if (c == "i") t = KwPri;
      KwPri:   if (c == "n") t = KwPrin;
      KwPrin:  if (c == "t") t = KwPrint;
      KwPrint: if (c == "f") t = KwPrintf;
      KwR:     if (c == "e") t = KwRe;
      KwRe:    if (c == "t") t = KwRet;
      KwRet:   if (c == "u") t = KwRetu;
      KwRetu:  if (c == "r") t = KwRetur;
      KwRetur: if (c == "n") t = KwReturn;
      default: t = KwDead;
    endcase
    return t;
  endfunction

  function automatic token_kind_e kw_kind(input logic [4:0] s);
    token_kind_e k;
    case (s)
      KwInt:    k = TK_INT;
      KwFloat:  k = TK_FLOAT;
      KwPrint:  k = TK_PRINT;
      KwPrintf: k = TK_PRINT;
      KwReturn: k = TK_RETURN;
      default:  k = TK_IDENT;
    endcase
    return k;
  endfunction

  function automatic token_kind_e op_kind(input logic [7:0] c);
    token_kind_e k;
    case (c)
      "=":     k = TK_ASSIGN;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_MUL;
      "/":     k = TK_DIV;
      ";":     k = TK_SEMI;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ----- src/csl_scan.sv -----
// Next-state and token logic for one source byte.
module csl_scan #(
  parameter int unsigned PosBits = 16
) (
  input  csl_pkg::csl_in_t   in_i,
  input  csl_pkg::scan_mode_e mode_i,
  input  logic [15:0]        line_i,
  input  logic [PosBits-1:0] pos_i,
  input  logic [PosBits-1:0] start_i,
  input  logic [PosBits-1:0] len_i,
  input  logic [4:0]         kw_i,
  output csl_pkg::scan_mode_e mode_o,
  output logic [15:0]        line_o,
  output logic [PosBits-1:0] pos_o,
  output logic [PosBits-1:0] start_o,
  output logic [PosBits-1:0] len_o,
  output logic [4:0]         kw_o,
  output csl_pkg::csl_out_t  res0_o,
  output csl_pkg::csl_out_t  res1_o,
  output logic [1:0]         res_cnt_o
);
  import csl_pkg::*;

  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);

  function automatic logic [15:0] sat16(input logic [PosBits-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    return (x > 32'h0000_FFFF) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  logic [7:0] c;
  logic       flush_v, tok_v;
  csl_out_t   flush_r, tok_r;
  logic [15:0] line_inc;

  assign c = in_i.char_byte;
  assign line_inc = (line_i == 16'hFFFF) ? line_i : line_i + 16'd1;

  always_comb begin
    mode_o  = mode_i;
    line_o  = line_i;
    pos_o   = pos_i;
    start_o = start_i;
    len_o   = len_i;
    kw_o    = kw_i;
    flush_v = 1'b0;
    tok_v   = 1'b0;

    // Pending identifier or number, as it would be flushed now.
    flush_r.token_kind    = (mode_i == MODE_IDENT) ? kw_kind(kw_i) : TK_NUM;
    flush_r.line_number   = line_i;
    flush_r.start_offset  = sat16(start_i);
    flush_r.token_length  = sat16(len_i);
    flush_r.lexical_error = 1'b0;
    flush_r.last_of_run   = 1'b0;

    tok_r.token_kind    = op_kind(c);
    tok_r.line_number   = line_i;
    tok_r.start_offset  = sat16(pos_i);
    tok_r.token_length  = 16'd1;
    tok_r.lexical_error = (op_kind(c) == TK_UNKNOWN);
    tok_r.last_of_run   = 1'b0;

    if (in_i.end_of_source) begin
      flush_v = (mode_i == MODE_IDENT) || (mode_i == MODE_NUM);
      tok_v   = 1'b1;
      tok_r.token_kind    = TK_EOF;
      tok_r.line_number   = (mode_i == MODE_COMMENT) ? line_inc : line_i;
      tok_r.token_length  = 16'd0;
      tok_r.lexical_error = 1'b0;
      mode_o  = MODE_IDLE;
      line_o  = 16'd1;
      pos_o   = '0;
      start_o = '0;
      len_o   = '0;
      kw_o    = KwStart;
    end else begin
      pos_o = sat_inc(pos_i);
      if (mode_i == MODE_COMMENT) begin
        if (c == ChLf) begin
          line_o = line_inc;
          mode_o = MODE_IDLE;
        end
      end else if (mode_i == MODE_IDENT &&
                   (is_letter(c) || is_digit(c) || c == ChUscore)) begin
        len_o = sat_inc(len_i);
        kw_o  = kw_next(kw_i, c);
      end else if (mode_i == MODE_NUM && (is_digit(c) || c == ChDot)) begin
        len_o = sat_inc(len_i);
      end else begin
        flush_v = (mode_i == MODE_IDENT) || (mode_i == MODE_NUM);
        mode_o  = MODE_IDLE;
        if (c == ChHash) begin
          mode_o = MODE_COMMENT;
        end else if (is_space(c)) begin
          if (c == ChLf) line_o = line_inc;
        end else if (is_letter(c)) begin
          mode_o  = MODE_IDENT;
          start_o = pos_i;
          len_o   = PosOne;
          kw_o    = kw_next(KwStart, c);
        end else if (is_digit(c)) begin
          mode_o  = MODE_NUM;
          start_o = pos_i;
          len_o   = PosOne;
        end else begin
          tok_v = 1'b1;
        end
      end
    end

    // Pack: flushed token goes first; the last one carries the run flag.
    res0_o = flush_v ? flush_r : tok_r;
    res1_o = tok_r;
    res_cnt_o = {1'b0, flush_v} + {1'b0, tok_v};
    if (flush_v && tok_v) begin
      res1_o.last_of_run = 1'b1;
    end else begin
      res0_o.last_of_run = 1'b1;
    end
  end

endmodule

// ----- src/csl_res_fifo.sv -----
// Result queue: takes up to two tokens per cycle, gives one when ready.
module csl_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  csl_pkg::csl_out_t push0_i,
  input  csl_pkg::csl_out_t push1_i,
  output logic              room2_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csl_pkg::csl_out_t out_o
);
  import csl_pkg::*;

  localparam logic [ResCntBits-1:0] CntMax   = ResCntBits'(ResDepth);
  localparam logic [ResCntBits-1:0] CntRoom2 = ResCntBits'(ResDepth - 2);

  csl_out_t                mem_q [ResDepth];
  logic [ResPtrBits-1:0]   wp_q, wp_d, rp_q, rp_d, wp1;
  logic [ResCntBits-1:0]   cnt_q, cnt_d;
  logic                    pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rp_q];
  assign room2_o     = (cnt_q <= CntRoom2);
  assign wp1         = wp_q + ResPtrBits'(1);

  always_comb begin
    wp_d  = wp_q + ResPtrBits'(push_cnt_i);
    rp_d  = pop ? rp_q + ResPtrBits'(1) : rp_q;
    cnt_d = cnt_q + ResCntBits'(push_cnt_i) - ResCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wp_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wp1]  <= push1_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax) else $error("result queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (ResCntBits'(push_cnt_i) + cnt_q <= CntMax))
    else $error("result queue overflow");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt_i == 2'd0) |=> (cnt_q == $past(cnt_q) - ResCntBits'(1)))
    else $error("result queue count wrong after pop");
`endif

endmodule

// ----- src/c_subset_lexer.sv -----
// Top level of the byte-serial C subset lexer.
// The lexer takes one source byte per input transaction and reports tokens
// as kind, line, start offset and length; end_of_source flushes any pending
// identifier or number and then gives an EOF token, after which all state is
// back at reset for the next source. The scan state registers and the token
// logic sit in a single registered pass, so bytes may arrive back to back
// while in_ready_o is high. One byte gives at most two tokens (a flushed
// pending token plus an operator, unknown byte or EOF). Tokens go into a
// four-entry result queue; in_ready_o is high while two queue slots are
// free, so the input stalls only when the output side falls behind.
// Tokens enter the queue as their byte is accepted. Positions are tracked
// on POSITION_BITS bits and saturate; output fields saturate at 16 bits.
module c_subset_lexer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  csl_pkg::csl_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csl_pkg::csl_out_t out_o
);
  import csl_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  scan_mode_e               mode_q, mode_d;
  logic [15:0]              line_q, line_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] len_q, len_d;
  logic [4:0]               kw_q, kw_d;

  csl_out_t   res0, res1;
  logic [1:0] res_cnt, push_cnt;
  logic       accept, room2;

  // A transaction is taken only while the queue can absorb two tokens.
  assign in_ready_o = room2;
  assign accept     = in_valid_i && in_ready_o;
  assign push_cnt   = accept ? res_cnt : 2'd0;

  csl_scan #(
    .PosBits(POSITION_BITS)
  ) u_scan (
    .in_i      (in_i),
    .mode_i    (mode_q),
    .line_i    (line_q),
    .pos_i     (pos_q),
    .start_i   (start_q),
    .len_i     (len_q),
    .kw_i      (kw_q),
    .mode_o    (mode_d),
    .line_o    (line_d),
    .pos_o     (pos_d),
    .start_o   (start_d),
    .len_o     (len_d),
    .kw_o      (kw_d),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  // Scan state advances only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= 16'd1;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      kw_q    <= KwStart;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
    end
  end

  csl_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.end_of_source) |=>
      (mode_q == MODE_IDLE && line_q == 16'd1 && pos_q == '0))
    else $error("state not cleared after end of source");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.end_of_source) |=>
      (pos_q == (($past(pos_q) == PosMax) ? PosMax : $past(pos_q) + 1'b1)))
    else $error("byte position did not advance");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != 16'd0) else $error("line counter wrapped to zero");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (pos_q == $past(pos_q) && line_q == $past(line_q)))
    else $error("scan state changed without a transaction");
`endif

endmodule

// ----- test/token_checker.sv -----
// Token checker for the C subset lexer: predicts tokens from accepted bytes and compares.
`timescale 1ns / 1ps

module token_checker #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  csl_pkg::csl_in_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  csl_pkg::csl_out_t out_i,
  output int                errors_o,
  output int                pending_o,
  output int                checked_o,
  output int                bytes_o,
  output int                sources_o,
  output logic [17:0]       kinds_seen_o
);
  import csl_pkg::*;

  typedef logic [POSITION_BITS-1:0] pos_t;

  // Scanner state kept by the checker.
  scan_mode_e  mode;
  logic [15:0] line_no;
  pos_t        pos;
  pos_t        tok_pos;
  pos_t        tok_cnt;
  logic [47:0] id_tail;    // last six identifier bytes
  int unsigned id_chars;   // identifier length, held at 7

  csl_out_t    tokens_due[$];
  csl_out_t    step_tokens[$];

  int          errors;
  int          checked;
  int          bytes_fed;
  int          sources;
  logic [17:0] kinds_seen;

  assign errors_o     = errors;
  assign pending_o    = tokens_due.size();
  assign checked_o    = checked;
  assign bytes_o      = bytes_fed;
  assign sources_o    = sources;
  assign kinds_seen_o = kinds_seen;

  function automatic logic [15:0] clip16(input pos_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic pos_t pos_inc(input pos_t v);
    return (v == {POSITION_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic token_kind_e punct_kind(input logic [7:0] c);
    case (c)
      "=":     return TK_ASSIGN;
      "+":     return TK_PLUS;
      "-":     return TK_MINUS;
      "*":     return TK_MUL;
      "/":     return TK_DIV;
      ";":     return TK_SEMI;
      "(":     return TK_LPAREN;
      ")":     return TK_RPAREN;
      "{":     return TK_LBRACE;
      "}":     return TK_RBRACE;
      default: return TK_UNKNOWN;
    endcase
  endfunction

  // Keyword test on the identifier text itself; printf reports as print.
  function automatic token_kind_e ident_kind();
    if (id_chars == 3 && id_tail[23:0] == "int") return TK_INT;
    if (id_chars == 5 && id_tail[39:0] == "float") return TK_FLOAT;
    if (id_chars == 5 && id_tail[39:0] == "print") return TK_PRINT;
    if (id_chars == 6 && id_tail == "printf") return TK_PRINT;
    if (id_chars == 6 && id_tail == "return") return TK_RETURN;
    return TK_IDENT;
  endfunction

  function automatic csl_out_t make_token(input token_kind_e k, input pos_t start,
                                          input pos_t len, input logic err);
    csl_out_t t;
    t.token_kind    = k;
    t.line_number   = line_no;
    t.start_offset  = clip16(start);
    t.token_length  = clip16(len);
    t.lexical_error = err;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  task automatic reset_scan();
    mode     = MODE_IDLE;
    line_no  = 16'd1;
    pos      = '0;
    tok_pos  = '0;
    tok_cnt  = '0;
    id_tail  = '0;
    id_chars = 0;
  endtask

  task automatic bump_line();
    if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
  endtask

  // Appends one predicted token for the current step.
  task automatic add_token(input csl_out_t t);
    step_tokens = {step_tokens, t};
  endtask

  task automatic flush_pending();
    if (mode == MODE_IDENT) add_token(make_token(ident_kind(), tok_pos, tok_cnt, 1'b0));
    else if (mode == MODE_NUM) add_token(make_token(TK_NUM, tok_pos, tok_cnt, 1'b0));
    if (mode != MODE_COMMENT) mode = MODE_IDLE;
  endtask

  // Works out the tokens one accepted byte (or end of source) gives.
  task automatic scan_byte(input csl_in_t item);
    logic [7:0]  c;
    token_kind_e k;
    c = item.char_byte;
    step_tokens.delete();
    if (item.end_of_source) begin
      sources++;
      flush_pending();
      if (mode == MODE_COMMENT) bump_line();
      add_token(make_token(TK_EOF, pos, '0, 1'b0));
      reset_scan();
    end else begin
      bytes_fed++;
      if (mode == MODE_COMMENT) begin
        if (c == ChLf) begin
          bump_line();
          mode = MODE_IDLE;
        end
      end else if (mode == MODE_IDENT &&
                   (letter_byte(c) || digit_byte(c) || c == ChUscore)) begin
        tok_cnt = pos_inc(tok_cnt);
        id_tail = {id_tail[39:0], c};
        if (id_chars < 7) id_chars++;
      end else if (mode == MODE_NUM && (digit_byte(c) || c == ChDot)) begin
        tok_cnt = pos_inc(tok_cnt);
      end else begin
        flush_pending();
        if (c == ChHash) begin
          mode = MODE_COMMENT;
        end else if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
          if (c == ChLf) bump_line();
        end else if (letter_byte(c)) begin
          mode     = MODE_IDENT;
          tok_pos  = pos;
          tok_cnt  = pos_t'(1);
          id_tail  = {40'b0, c};
          id_chars = 1;
        end else if (digit_byte(c)) begin
          mode    = MODE_NUM;
          tok_pos = pos;
          tok_cnt = pos_t'(1);
        end else begin
          k = punct_kind(c);
          add_token(make_token(k, pos, pos_t'(1), k == TK_UNKNOWN));
        end
      end
      pos = pos_inc(pos);
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
    foreach (step_tokens[i]) tokens_due = {tokens_due, step_tokens[i]};
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got, inout logic bad);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic compare_token(input csl_out_t got);
    csl_out_t want;
    logic     bad;
    if (tokens_due.size() == 0) begin
      $display({"%0t: token with none expected, expected none, ",
                "actual kind %0d line %0d start %0d len %0d"},
               $realtime, got.token_kind, got.line_number, got.start_offset,
               got.token_length);
      errors++;
    end else begin
      want = tokens_due.pop_front();
      bad  = 1'b0;
      check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind), bad);
      check_field("line_number", want.line_number, got.line_number, bad);
      check_field("start_offset", want.start_offset, got.start_offset, bad);
      check_field("token_length", want.token_length, got.token_length, bad);
      check_field("lexical_error", 16'(want.lexical_error), 16'(got.lexical_error), bad);
      check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run), bad);
      if (bad) errors++;
      checked++;
      if (want.token_kind < 18) kinds_seen[want.token_kind] = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scan();
      tokens_due.delete();
      errors     = 0;
      checked    = 0;
      bytes_fed  = 0;
      sources    = 0;
      kinds_seen = '0;
    end else begin
      if (in_valid_i && in_ready_i) scan_byte(in_i);
      if (out_valid_i && out_ready_i) compare_token(out_i);
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the lexer testbench: clock, reset, source byte stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
  import csl_pkg::*;

  localparam int unsigned PosBits     = 16;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 1550;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid;
  logic     in_ready;
  csl_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  csl_out_t out_data;

  int          errors;
  int          pending;
  int          checked;
  int          bytes_fed;
  int          sources;
  logic [17:0] kinds_seen;

  // Sender idling knob; some sources run without input gaps.
  bit in_gaps_on = 1'b1;

  int unsigned random_items;
  int unsigned cycles;

  // Identifier pool: all keywords plus near misses (prefixes, extensions, case).
  string kw_list[16] = '{"int", "float", "print", "printf", "return", "in", "flo", "prin",
                         "printff", "returned", "Int", "retur", "f", "intx", "i9", "float_"};
  string op_chars    = "=+-*/;(){}";
  string odd_chars   = "!\"$%&'<>?@[\\]^|~,._:";

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  c_subset_lexer #(
    .POSITION_BITS(PosBits)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  token_checker #(
    .POSITION_BITS(PosBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_data),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .bytes_o      (bytes_fed),
    .sources_o    (sources),
    .kinds_seen_o (kinds_seen)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d tokens outstanding",
               $realtime, cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Sender-side gap before a transaction: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!in_gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver backpressure. The high phase is never empty, so out_ready
  // never gets two updates in one step; long stall-free stretches show up too.
  initial begin
    int unsigned on_len;
    int unsigned off_len;
    out_ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      off_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_ready <= 1'b1;
      repeat (on_len) @(negedge clk_i);
      if (off_len != 0) begin
        out_ready <= 1'b0;
        repeat (off_len) @(negedge clk_i);
      end
    end
  end

  // One input transaction. Entered and left at a falling edge; valid stays up
  // with a stable payload until a rising edge sees ready.
  task automatic push_item(input logic [7:0] c, input logic eos);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_byte: c, end_of_source: eos};
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    random_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  // End of source; the byte lane carries junk that must be ignored.
  task automatic push_eof();
    push_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 9) return 8'("0" + $urandom_range(0, 9));
    return ChUscore;
  endfunction

  // Whitespace, biased to space and newline.
  function automatic logic [7:0] rand_blank();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return " ";
    if (r < 7) return ChLf;
    if (r == 7) return 8'h09;
    if (r == 8) return 8'h0D;
    return 8'($urandom_range(8'h0B, 8'h0C));
  endfunction

  // Bytes that lex as unknown: high bytes, stray punctuation, control codes.
  function automatic logic [7:0] rand_odd_byte();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 2);
    if (r == 0) return 8'($urandom_range(128, 255));
    if (r == 1) return odd_chars[$urandom_range(0, odd_chars.len() - 1)];
    v = $urandom_range(0, 26);
    if (v < 9) return 8'(v);
    if (v < 26) return 8'(v + 5);
    return 8'h7F;
  endfunction

  // Comment body: anything but newline, then the closing newline when closed is set.
  task automatic push_comment(input bit closed);
    logic [7:0] c;
    push_item(ChHash, 1'b0);
    repeat ($urandom_range(0, 12)) begin
      c = 8'($urandom_range(0, 255));
      if (c == ChLf) c = "x";
      push_item(c, 1'b0);
    end
    if (closed) push_item(ChLf, 1'b0);
  endtask

  task automatic push_random_token();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      push_text(kw_list[$urandom_range(0, 15)]);
    end else if (pick < 35) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      push_item(rand_letter(), 1'b0);
      repeat (len - 1) push_item(rand_word_char(), 1'b0);
    end else if (pick < 50) begin
      // number: leading digit, then digits and dots
      push_item(8'("0" + $urandom_range(0, 9)), 1'b0);
      repeat ($urandom_range(0, 7)) begin
        if ($urandom_range(0, 3) == 0) push_item(ChDot, 1'b0);
        else push_item(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
    end else if (pick < 72) begin
      push_item(op_chars[$urandom_range(0, 9)], 1'b0);
    end else if (pick < 80) begin
      push_comment(1'b1);
    end else if (pick < 90) begin
      push_item(rand_odd_byte(), 1'b0);
    end else begin
      push_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // A source is a run of tokens, usually separated, sometimes glued together,
  // closed by end of source; now and then the source ends inside a comment
  // or right in the middle of an identifier or number.
  task automatic push_random_source();
    int unsigned n_tok;
    in_gaps_on = ($urandom_range(0, 3) != 0);
    n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 25);
    repeat (n_tok) begin
      push_random_token();
      if ($urandom_range(0, 2) != 0) push_item(rand_blank(), 1'b0);
    end
    case ($urandom_range(0, 5))
      0: push_comment(1'b0);
      1: push_random_token();
      default: ;
    endcase
    push_eof();
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every operator, the byte extremes, tab, an identifier with
    // digit and underscore cut off by a comment, a number ending in a dot
    // flushed by an unknown byte, then a source that ends inside a comment.
    push_text("=+-*/;(){}");
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h09, 1'b0);
    push_text("a_9");
    push_item(ChHash, 1'b0);
    push_text("q");
    push_item(ChLf, 1'b0);
    push_text("7.@");
    push_eof();
    push_item(ChHash, 1'b0);
    push_eof();

    // Random sources.
    random_items = 0;
    while (random_items < RandomItems) push_random_source();
    in_valid <= 1'b0;

    // Drain and give late tokens time to show up; the watchdog bounds this.
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Summary: %0d source bytes in %0d sources, %0d tokens compared.",
             bytes_fed, sources, checked);
    $display("Summary: %0d of 18 token kinds seen, with comments, stalls and glued tokens.",
             $countones(kinds_seen));
    if (pending != 0) $display("%0t: %0d expected tokens never arrived", $realtime, pending);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
